>>> hw/rtl/bps_pkg.sv
// Package of the burn phase sequencer: phase and status codes, command and
// register index codes, configuration and item structs, flap saturation.
// No dependencies.
package bps_pkg;

    typedef enum logic [2:0] {
        PH_ESTOP   = 3'd0,
        PH_STOP    = 3'd1,
        PH_START   = 3'd2,
        PH_BURN    = 3'd3,
        PH_BURNOUT = 3'd4,
        PH_GLOW    = 3'd5,
        PH_VENT    = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        ST_STOPPED  = 2'd0,
        ST_STARTING = 2'd1,
        ST_BURNING  = 2'd2,
        ST_LOWFUEL  = 2'd3
    } t_status;

    localparam logic [2:0] MODE_START   = 3'd1;
    localparam logic [2:0] MODE_STOP    = 3'd2;
    localparam logic [2:0] MODE_RESTART = 3'd3;
    localparam logic [2:0] MODE_ESTOP   = 3'd4;

    localparam logic [2:0] CFG_START_TIMEOUT   = 3'd0;
    localparam logic [2:0] CFG_MIN_BURN_TEMP   = 3'd1;
    localparam logic [2:0] CFG_BURNOUT_TEMP    = 3'd2;
    localparam logic [2:0] CFG_BURNOUT_TIMEOUT = 3'd3;
    localparam logic [2:0] CFG_GLOW_TEMP       = 3'd4;
    localparam logic [2:0] CFG_BURNOUT_FLAP    = 3'd5;
    localparam logic [2:0] CFG_GLOW_TIMEOUT    = 3'd6;
    localparam logic [2:0] CFG_GLOW_FLAP       = 3'd7;

    localparam logic [9:0]  FLAP_MAX   = 10'd1000;
    localparam logic [9:0]  FLAP_START = 10'd100;
    localparam logic [13:0] TIMER_MAX  = 14'd16383;
    localparam logic [13:0] HYST_LOW   = 14'd30;
    localparam logic [13:0] HYST_HIGH  = 14'd100;

    typedef struct packed {
        logic [7:0]  start_timeout_min;
        logic [12:0] min_burn_temp;
        logic [12:0] burnout_temp;
        logic [7:0]  burnout_timeout_min;
        logic [12:0] glow_temp;
        logic [9:0]  burnout_flap;
        logic [7:0]  glow_timeout;
        logic [9:0]  glow_flap;
    } t_cfg;

    typedef struct packed {
        logic [12:0] flue_temp;
        logic        door_open;
        logic        sensor_ok;
        logic [2:0]  mode;
        logic [9:0]  regulator_flap;
    } t_tick;

    typedef struct packed {
        logic [9:0] primary_flap;
        logic [2:0] phase_code;
        logic [1:0] burn_status;
        logic       regulator_reset;
    } t_result;

    function automatic logic [9:0] sat_flap(input logic [9:0] v);
        return (v > FLAP_MAX) ? FLAP_MAX : v;
    endfunction

endpackage

>>> hw/rtl/bps_if.sv
// Channel interfaces of the burn phase sequencer: tick words in, result words
// out, and the configuration write channel. No dependencies.
interface bps_tick_if;
    logic        valid;
    logic        ready;
    logic [12:0] flue_temp;
    logic        door_open;
    logic        sensor_ok;
    logic [2:0]  mode;
    logic [9:0]  regulator_flap;

    modport source (output valid, flue_temp, door_open, sensor_ok, mode, regulator_flap,
                    input ready);
    modport sink   (input valid, flue_temp, door_open, sensor_ok, mode, regulator_flap,
                    output ready);
endinterface

interface bps_result_if;
    logic       valid;
    logic       ready;
    logic [9:0] primary_flap;
    logic [2:0] phase_code;
    logic [1:0] burn_status;
    logic       regulator_reset;

    modport source (output valid, primary_flap, phase_code, burn_status, regulator_reset,
                    input ready);
    modport sink   (input valid, primary_flap, phase_code, burn_status, regulator_reset,
                    output ready);
endinterface

interface bps_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [12:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> hw/rtl/bps_cfg_regs.sv
// Configuration register file of the burn phase sequencer.
// Depends on bps_pkg.
module bps_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_wr_en,
    input  logic [2:0]    i_wr_index,
    input  logic [12:0]   i_wr_data,
    output bps_pkg::t_cfg o_cfg
);

    bps_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_timeout_min   <= 8'd30;
            r_cfg.min_burn_temp       <= 13'd900;
            r_cfg.burnout_temp        <= 13'd800;
            r_cfg.burnout_timeout_min <= 8'd20;
            r_cfg.glow_temp           <= 13'd600;
            r_cfg.burnout_flap        <= 10'd15;
            r_cfg.glow_timeout        <= 8'd10;
            r_cfg.glow_flap           <= 10'd10;
        end else if (i_wr_en) begin
            unique case (i_wr_index)
                bps_pkg::CFG_START_TIMEOUT:   r_cfg.start_timeout_min   <= i_wr_data[7:0];
                bps_pkg::CFG_MIN_BURN_TEMP:   r_cfg.min_burn_temp       <= i_wr_data;
                bps_pkg::CFG_BURNOUT_TEMP:    r_cfg.burnout_temp        <= i_wr_data;
                bps_pkg::CFG_BURNOUT_TIMEOUT: r_cfg.burnout_timeout_min <= i_wr_data[7:0];
                bps_pkg::CFG_GLOW_TEMP:       r_cfg.glow_temp           <= i_wr_data;
                bps_pkg::CFG_BURNOUT_FLAP:    r_cfg.burnout_flap        <= i_wr_data[9:0];
                bps_pkg::CFG_GLOW_TIMEOUT:    r_cfg.glow_timeout        <= i_wr_data[7:0];
                bps_pkg::CFG_GLOW_FLAP:       r_cfg.glow_flap           <= i_wr_data[9:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> hw/rtl/bps_phase_fsm.sv
// Phase state machine of the burn phase sequencer: phase, status, flags,
// the two countdown timers and the held flap. Depends on bps_pkg.
module bps_phase_fsm #(
    parameter int TICKS_PER_UNIT   = 60,
    parameter int VENT_TIMEOUT_MIN = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_step,
    input  bps_pkg::t_tick   i_tick,
    input  bps_pkg::t_cfg    i_cfg,
    output bps_pkg::t_result o_result
);

    localparam int ProdBits = $clog2(255 * TICKS_PER_UNIT + 1);
    localparam int LoadW    = (ProdBits > 14) ? ProdBits : 14;
    localparam int VentRaw  = VENT_TIMEOUT_MIN * TICKS_PER_UNIT;
    localparam logic [13:0] VentLoad = (VentRaw > 16383) ? 14'd16383 : 14'(VentRaw);

    function automatic logic [13:0] load_time(input logic [7:0] units);
        logic [LoadW-1:0] prod;
        prod = LoadW'(units) * LoadW'(TICKS_PER_UNIT);
        return (prod > LoadW'(bps_pkg::TIMER_MAX)) ? bps_pkg::TIMER_MAX : prod[13:0];
    endfunction

    bps_pkg::t_phase  r_phase,   n_phase;
    bps_pkg::t_status r_status,  n_status;
    logic             r_init,    n_init;
    logic             r_started, n_started;
    logic             r_restart, n_restart;
    logic [13:0]      r_ptimer,  n_ptimer;
    logic [13:0]      r_ltimer,  n_ltimer;
    logic [9:0]       r_flap,    n_flap;
    logic             n_pulse;

    logic [13:0] temp_w;
    logic [13:0] start_load;
    logic [13:0] burnout_load;
    logic [13:0] glow_load;
    logic [9:0]  reg_flap;

    assign temp_w       = {1'b0, i_tick.flue_temp};
    assign start_load   = load_time(i_cfg.start_timeout_min);
    assign burnout_load = load_time(i_cfg.burnout_timeout_min);
    assign glow_load    = load_time(i_cfg.glow_timeout);
    assign reg_flap     = bps_pkg::sat_flap(i_tick.regulator_flap);

    always_comb begin
        n_phase   = r_phase;
        n_status  = r_status;
        n_init    = r_init;
        n_started = r_started;
        n_restart = r_restart;
        n_ltimer  = r_ltimer;
        n_flap    = r_flap;
        n_pulse   = 1'b0;
        n_ptimer  = (r_ptimer != 14'd0) ? r_ptimer - 14'd1 : r_ptimer;

        // Command first, then one step of the phase logic.
        unique case (i_tick.mode)
            bps_pkg::MODE_START: begin
                if (r_phase != bps_pkg::PH_ESTOP) begin
                    n_status  = bps_pkg::ST_STARTING;
                    n_phase   = bps_pkg::PH_START;
                    n_started = 1'b1;
                    n_init    = 1'b1;
                end
            end
            bps_pkg::MODE_STOP: begin
                n_flap    = bps_pkg::FLAP_START;
                n_init    = 1'b0;
                n_status  = bps_pkg::ST_STOPPED;
                n_phase   = bps_pkg::PH_STOP;
                n_started = 1'b0;
            end
            bps_pkg::MODE_RESTART: n_restart = 1'b1;
            bps_pkg::MODE_ESTOP:   n_phase = bps_pkg::PH_ESTOP;
            default: ;
        endcase

        if (i_tick.door_open) begin
            n_flap = 10'd0;
        end else begin
            unique case (n_phase)
                bps_pkg::PH_ESTOP: begin
                    n_flap   = 10'd0;
                    n_init   = 1'b0;
                    n_status = bps_pkg::ST_STOPPED;
                    if (n_restart) begin
                        n_restart = 1'b0;
                        if (n_started) begin
                            n_status = bps_pkg::ST_STARTING;
                            n_phase  = bps_pkg::PH_START;
                            n_init   = 1'b1;
                        end else begin
                            n_phase = bps_pkg::PH_STOP;
                        end
                    end
                end
                bps_pkg::PH_START: begin
                    // A faulty sensor keeps the phase waiting in its init step.
                    if (!(n_init && !i_tick.sensor_ok)) begin
                        if (n_init) begin
                            n_ptimer = start_load;
                            n_status = bps_pkg::ST_STARTING;
                            n_init   = 1'b0;
                        end
                        n_flap = bps_pkg::FLAP_START;
                        if (n_ptimer == 14'd0 || i_tick.flue_temp >= i_cfg.min_burn_temp) begin
                            n_phase = bps_pkg::PH_BURN;
                            n_init  = 1'b1;
                        end
                    end
                end
                bps_pkg::PH_BURN: begin
                    if (n_init) begin
                        n_init   = 1'b0;
                        n_status = bps_pkg::ST_BURNING;
                        n_ltimer = burnout_load;
                        n_pulse  = 1'b1;
                    end
                    if (temp_w > {1'b0, i_cfg.burnout_temp} + bps_pkg::HYST_LOW) begin
                        n_ltimer = burnout_load;
                    end
                    if (i_tick.flue_temp < i_cfg.burnout_temp && n_ltimer != 14'd0) begin
                        n_ltimer = n_ltimer - 14'd1;
                    end
                    if (n_ltimer == 14'd0) begin
                        n_phase = bps_pkg::PH_BURNOUT;
                        n_init  = 1'b1;
                    end else begin
                        n_flap = reg_flap;
                    end
                end
                bps_pkg::PH_BURNOUT: begin
                    if (n_init) begin
                        n_init   = 1'b0;
                        n_status = bps_pkg::ST_LOWFUEL;
                        n_ltimer = burnout_load;
                    end
                    n_flap = bps_pkg::sat_flap(i_cfg.burnout_flap);
                    if (i_tick.flue_temp > i_cfg.min_burn_temp) begin
                        n_phase = bps_pkg::PH_BURN;
                        n_init  = 1'b1;
                    end
                    if (temp_w > {1'b0, i_cfg.glow_temp} + bps_pkg::HYST_LOW) begin
                        n_ltimer = burnout_load;
                    end
                    if (i_tick.flue_temp < i_cfg.glow_temp && n_ltimer != 14'd0) begin
                        n_ltimer = n_ltimer - 14'd1;
                    end
                    if (n_ltimer == 14'd0) begin
                        n_phase = bps_pkg::PH_GLOW;
                        n_init  = 1'b1;
                    end
                end
                bps_pkg::PH_GLOW: begin
                    if (n_init) begin
                        n_ptimer = glow_load;
                        n_init   = 1'b0;
                        n_status = bps_pkg::ST_BURNING;
                    end
                    n_flap = bps_pkg::sat_flap(i_cfg.glow_flap);
                    if (n_ptimer == 14'd0) begin
                        n_phase = bps_pkg::PH_VENT;
                        n_init  = 1'b1;
                    end else if (temp_w > {1'b0, i_cfg.glow_temp} + bps_pkg::HYST_HIGH) begin
                        n_phase = bps_pkg::PH_BURNOUT;
                        n_init  = 1'b1;
                    end
                end
                bps_pkg::PH_VENT: begin
                    if (n_init) begin
                        n_ptimer = VentLoad;
                        n_init   = 1'b0;
                        n_status = bps_pkg::ST_STOPPED;
                    end
                    n_flap = bps_pkg::FLAP_MAX;
                    if (n_ptimer == 14'd0) begin
                        n_phase = bps_pkg::PH_STOP;
                        n_init  = 1'b0;
                    end
                end
                default: begin
                    // Stop phase, and any code without a phase of its own.
                    n_phase  = bps_pkg::PH_STOP;
                    n_flap   = 10'd0;
                    n_init   = 1'b0;
                    n_status = bps_pkg::ST_STOPPED;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= bps_pkg::PH_STOP;
            r_status  <= bps_pkg::ST_STOPPED;
            r_init    <= 1'b0;
            r_started <= 1'b0;
            r_restart <= 1'b0;
            r_ptimer  <= 14'd0;
            r_ltimer  <= 14'd0;
            r_flap    <= 10'd0;
        end else if (i_step) begin
            r_phase   <= n_phase;
            r_status  <= n_status;
            r_init    <= n_init;
            r_started <= n_started;
            r_restart <= n_restart;
            r_ptimer  <= n_ptimer;
            r_ltimer  <= n_ltimer;
            r_flap    <= n_flap;
        end
    end

    assign o_result.primary_flap    = n_flap;
    assign o_result.phase_code      = n_phase;
    assign o_result.burn_status     = n_status;
    assign o_result.regulator_reset = n_pulse;

endmodule

>>> hw/rtl/burn_phase_sequencer.sv
// Top level of the burn phase sequencer: input word register, phase state
// machine, result register. Depends on bps_pkg, bps_if, bps_cfg_regs and
// bps_phase_fsm.
//
// Usage: one tick word per one-second tick enters on i_tick (flue temperature,
// door and sensor state, command, regulator flap demand). Each word yields
// exactly one result word on o_result (flap command, phase, status and the
// regulator reset pulse). Configuration registers are written through i_cfg,
// which is always ready; write them only while no word is in flight.
// From acceptance, a tick word waits in the input register while the phase
// logic works on it, and the result register takes the outcome once it is
// free or emptying, whereupon the result is valid. Throughput is one word per
// cycle while the receiver takes every result, set by the single pass of the
// phase logic from the input register to the result register.
// A stalled receiver holds the result register; the input register still
// takes one more word, after which i_tick.ready drops until the result is
// taken. Synchronous reset puts the block in the stop phase with both timers
// at zero, the flap closed and the configuration at its default values.
module burn_phase_sequencer #(
    parameter int TICKS_PER_UNIT   = 60,
    parameter int VENT_TIMEOUT_MIN = 1
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    bps_tick_if.sink       i_tick,
    bps_cfg_if.sink        i_cfg,
    bps_result_if.source   o_result
);

    bps_pkg::t_cfg    cfg;
    bps_pkg::t_result fsm_result;

    logic             r_in_valid;
    bps_pkg::t_tick   r_in;
    logic             r_out_valid;
    bps_pkg::t_result r_out;
    logic             step;

    assign i_cfg.ready = 1'b1;

    bps_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg.valid),
        .i_wr_index (i_cfg.index),
        .i_wr_data  (i_cfg.data),
        .o_cfg      (cfg)
    );

    // The held word moves on whenever the result register is free or emptying.
    assign step         = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_tick.ready = !r_in_valid || step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_tick.ready) begin
            r_in_valid <= i_tick.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_tick.valid && i_tick.ready) begin
            r_in.flue_temp      <= i_tick.flue_temp;
            r_in.door_open      <= i_tick.door_open;
            r_in.sensor_ok      <= i_tick.sensor_ok;
            r_in.mode           <= i_tick.mode;
            r_in.regulator_flap <= i_tick.regulator_flap;
        end
    end

    bps_phase_fsm #(
        .TICKS_PER_UNIT   (TICKS_PER_UNIT),
        .VENT_TIMEOUT_MIN (VENT_TIMEOUT_MIN)
    ) u_phase_fsm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_tick   (r_in),
        .i_cfg    (cfg),
        .o_result (fsm_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= fsm_result;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.primary_flap    = r_out.primary_flap;
    assign o_result.phase_code      = r_out.phase_code;
    assign o_result.burn_status     = r_out.burn_status;
    assign o_result.regulator_reset = r_out.regulator_reset;

endmodule

>>> dv/tb.sv
// Self-checking testbench of burn_phase_sequencer: random and directed tick words
// with random idling on both channels, and a built-in predictor of the phase logic.
// Depends on bps_pkg, bps_if and the RTL of the block.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bps_pkg::*;

    localparam int HALF_PERIOD      = 6;
    localparam int TICKS_PER_MINUTE = 60;
    localparam int VENT_MINUTES     = 1;
    localparam int ITEMS_PER_SET    = 290;
    localparam int CYCLE_LIMIT      = 400000;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    always #HALF_PERIOD i_clk = ~i_clk;

    bps_tick_if   tick_ch ();
    bps_result_if result_ch ();
    bps_cfg_if    cfg_ch ();

    // Everything the testbench drives lives in its own variables, known from time zero.
    logic        tick_valid   = 1'b0;
    t_tick       on_bus       = '0;
    logic        result_ready = 1'b0;
    logic        cfg_valid    = 1'b0;
    logic [2:0]  cfg_index    = '0;
    logic [12:0] cfg_data     = '0;

    assign tick_ch.valid          = tick_valid;
    assign tick_ch.flue_temp      = on_bus.flue_temp;
    assign tick_ch.door_open      = on_bus.door_open;
    assign tick_ch.sensor_ok      = on_bus.sensor_ok;
    assign tick_ch.mode           = on_bus.mode;
    assign tick_ch.regulator_flap = on_bus.regulator_flap;
    assign result_ch.ready        = result_ready;
    assign cfg_ch.valid           = cfg_valid;
    assign cfg_ch.index           = cfg_index;
    assign cfg_ch.data            = cfg_data;

    burn_phase_sequencer #(
        .TICKS_PER_UNIT   (TICKS_PER_MINUTE),
        .VENT_TIMEOUT_MIN (VENT_MINUTES)
    ) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tick   (tick_ch),
        .i_cfg    (cfg_ch),
        .o_result (result_ch)
    );

    // Shadow of the configuration and of the sequencer state.
    t_cfg        cfg_q;
    t_phase      ph_q;
    t_status     st_q;
    bit          init_q;
    bit          started_q;
    bit          restart_q;
    logic [13:0] user_tmr;
    logic [13:0] cold_tmr;
    logic [9:0]  flap_q;

    t_tick   queued_ticks [$];
    t_result due_results [$];
    int      items_queued    = 0;
    int      results_checked = 0;
    int      mismatches      = 0;
    int      temp_band       = 3;
    int      cycle_count     = 0;

    function automatic logic [13:0] minutes_to_ticks(input logic [7:0] minutes);
        int t;
        t = int'(minutes) * TICKS_PER_MINUTE;
        return (t > int'(TIMER_MAX)) ? TIMER_MAX : 14'(t);
    endfunction

    function automatic logic [9:0] limit_flap(input logic [9:0] v);
        return (v > FLAP_MAX) ? FLAP_MAX : v;
    endfunction

    // One tick of the sequencer: command first, then the phase logic.
    function automatic t_result advance_sequencer(input t_tick tk);
        t_result r;
        bit      pulse;
        int      temp;
        pulse = 1'b0;
        temp  = int'(tk.flue_temp);

        if (user_tmr > 0) user_tmr = user_tmr - 14'd1;

        case (tk.mode)
            MODE_START: begin
                if (ph_q != PH_ESTOP) begin
                    st_q = ST_STARTING; ph_q = PH_START; started_q = 1'b1; init_q = 1'b1;
                end
            end
            MODE_STOP: begin
                flap_q = FLAP_START; init_q = 1'b0; st_q = ST_STOPPED;
                ph_q = PH_STOP; started_q = 1'b0;
            end
            MODE_RESTART: restart_q = 1'b1;
            MODE_ESTOP:   ph_q = PH_ESTOP;
            default: ;
        endcase

        if (tk.door_open) begin
            flap_q = '0;
        end else begin
            case (ph_q)
                PH_ESTOP: begin
                    flap_q = '0; init_q = 1'b0; st_q = ST_STOPPED;
                    if (restart_q) begin
                        restart_q = 1'b0;
                        if (started_q) begin
                            st_q = ST_STARTING; ph_q = PH_START; init_q = 1'b1;
                        end else begin
                            ph_q = PH_STOP;
                        end
                    end
                end
                PH_START: begin
                    // A faulty sensor keeps the start phase in its init step.
                    if (!init_q || tk.sensor_ok) begin
                        if (init_q) begin
                            user_tmr = minutes_to_ticks(cfg_q.start_timeout_min);
                            st_q = ST_STARTING;
                            init_q = 1'b0;
                        end
                        flap_q = FLAP_START;
                        if (user_tmr == 0 || tk.flue_temp >= cfg_q.min_burn_temp) begin
                            ph_q = PH_BURN; init_q = 1'b1;
                        end
                    end
                end
                PH_BURN: begin
                    if (init_q) begin
                        init_q = 1'b0;
                        st_q = ST_BURNING;
                        cold_tmr = minutes_to_ticks(cfg_q.burnout_timeout_min);
                        pulse = 1'b1;
                    end
                    if (temp > int'(cfg_q.burnout_temp) + int'(HYST_LOW))
                        cold_tmr = minutes_to_ticks(cfg_q.burnout_timeout_min);
                    if (tk.flue_temp < cfg_q.burnout_temp && cold_tmr > 0)
                        cold_tmr = cold_tmr - 14'd1;
                    if (cold_tmr == 0) begin
                        ph_q = PH_BURNOUT; init_q = 1'b1;
                    end else begin
                        flap_q = limit_flap(tk.regulator_flap);
                    end
                end
                PH_BURNOUT: begin
                    if (init_q) begin
                        init_q = 1'b0;
                        st_q = ST_LOWFUEL;
                        cold_tmr = minutes_to_ticks(cfg_q.burnout_timeout_min);
                    end
                    flap_q = limit_flap(cfg_q.burnout_flap);
                    if (tk.flue_temp > cfg_q.min_burn_temp) begin
                        ph_q = PH_BURN; init_q = 1'b1;
                    end
                    if (temp > int'(cfg_q.glow_temp) + int'(HYST_LOW))
                        cold_tmr = minutes_to_ticks(cfg_q.burnout_timeout_min);
                    if (tk.flue_temp < cfg_q.glow_temp && cold_tmr > 0)
                        cold_tmr = cold_tmr - 14'd1;
                    if (cold_tmr == 0) begin
                        ph_q = PH_GLOW; init_q = 1'b1;
                    end
                end
                PH_GLOW: begin
                    if (init_q) begin
                        user_tmr = minutes_to_ticks(cfg_q.glow_timeout);
                        init_q = 1'b0;
                        st_q = ST_BURNING;
                    end
                    flap_q = limit_flap(cfg_q.glow_flap);
                    if (user_tmr == 0) begin
                        ph_q = PH_VENT; init_q = 1'b1;
                    end else if (temp > int'(cfg_q.glow_temp) + int'(HYST_HIGH)) begin
                        ph_q = PH_BURNOUT; init_q = 1'b1;
                    end
                end
                PH_VENT: begin
                    if (init_q) begin
                        user_tmr = minutes_to_ticks(8'(VENT_MINUTES));
                        init_q = 1'b0;
                        st_q = ST_STOPPED;
                    end
                    flap_q = FLAP_MAX;
                    if (user_tmr == 0) begin
                        ph_q = PH_STOP; init_q = 1'b0;
                    end
                end
                default: begin
                    ph_q = PH_STOP; flap_q = '0; init_q = 1'b0; st_q = ST_STOPPED;
                end
            endcase
        end

        r.primary_flap    = flap_q;
        r.phase_code      = ph_q;
        r.burn_status     = st_q;
        r.regulator_reset = pulse;
        return r;
    endfunction

    function automatic t_tick tick_of(input int temp, input bit door, input bit sens,
                                      input logic [2:0] mode, input int flap);
        t_tick tk;
        tk.flue_temp      = 13'(temp);
        tk.door_open      = door;
        tk.sensor_ok      = sens;
        tk.mode           = mode;
        tk.regulator_flap = 10'(flap);
        return tk;
    endfunction

    // Temperature inside a band that follows the current thresholds.
    function automatic logic [12:0] pick_temp(input int band);
        int lo, hi, t;
        int marks [15];
        case (band)
            0: begin lo = 0; hi = int'(cfg_q.glow_temp); end
            1: begin lo = int'(cfg_q.glow_temp); hi = int'(cfg_q.burnout_temp); end
            2: begin lo = int'(cfg_q.burnout_temp); hi = int'(cfg_q.min_burn_temp); end
            3: begin lo = int'(cfg_q.min_burn_temp); hi = 8191; end
            default: begin
                marks = '{int'(cfg_q.glow_temp) - 1, int'(cfg_q.glow_temp),
                          int'(cfg_q.glow_temp) + 30, int'(cfg_q.glow_temp) + 31,
                          int'(cfg_q.glow_temp) + 100, int'(cfg_q.glow_temp) + 101,
                          int'(cfg_q.burnout_temp) - 1, int'(cfg_q.burnout_temp),
                          int'(cfg_q.burnout_temp) + 30, int'(cfg_q.burnout_temp) + 31,
                          int'(cfg_q.min_burn_temp) - 1, int'(cfg_q.min_burn_temp),
                          int'(cfg_q.min_burn_temp) + 1, 0, 8191};
                t = marks[$urandom_range(0, 14)];
                lo = (t < 0) ? 0 : ((t > 8191) ? 8191 : t);
                hi = lo;
            end
        endcase
        if (lo > hi) begin
            t = lo; lo = hi; hi = t;
        end
        return 13'($urandom_range(lo, hi));
    endfunction

    // Mostly plausible ticks: a slowly wandering flue temperature, rare commands,
    // and now and then a word of pure noise.
    function automatic t_tick draw_tick();
        t_tick tk;
        int    cmd, pick;
        if ($urandom_range(0, 11) == 0) begin
            tk.flue_temp      = 13'($urandom);
            tk.door_open      = 1'($urandom);
            tk.sensor_ok      = 1'($urandom);
            tk.mode           = 3'($urandom);
            tk.regulator_flap = 10'($urandom);
            return tk;
        end
        if ($urandom_range(0, 39) == 0) begin
            pick = $urandom_range(0, 9);
            temp_band = (pick < 3) ? 0 : (pick == 3) ? 1 : (pick == 4) ? 2 : (pick < 8) ? 3 : 4;
        end
        tk.flue_temp = pick_temp(temp_band);
        tk.door_open = ($urandom_range(0, 24) == 0);
        tk.sensor_ok = ($urandom_range(0, 19) != 0);
        cmd = $urandom_range(0, 199);
        if (cmd < 186)      tk.mode = 3'd0;
        else if (cmd < 192) tk.mode = MODE_START;
        else if (cmd < 195) tk.mode = MODE_STOP;
        else if (cmd < 197) tk.mode = MODE_RESTART;
        else if (cmd < 199) tk.mode = MODE_ESTOP;
        else                tk.mode = 3'($urandom_range(5, 7));
        tk.regulator_flap = ($urandom_range(0, 9) == 0) ? 10'($urandom_range(990, 1023))
                                                         : 10'($urandom_range(0, 1000));
        return tk;
    endfunction

    task automatic offer(input t_tick tk);
        queued_ticks.push_back(tk);
        items_queued++;
    endtask

    task automatic settle();
        while (results_checked < items_queued) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic void flag_field(input string name, input logic [15:0] want,
                                       input logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Tick word driver: a random pause before each word, with calm stretches.
    int send_wait = 0;
    int send_calm = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tick_valid <= 1'b0;
        end else begin
            if (tick_valid && tick_ch.ready) due_results.push_back(advance_sequencer(on_bus));
            if (!tick_valid || tick_ch.ready) begin
                if (send_wait > 0) begin
                    send_wait--;
                    tick_valid <= 1'b0;
                end else if (queued_ticks.size() > 0) begin
                    on_bus     <= queued_ticks.pop_front();
                    tick_valid <= 1'b1;
                    if (send_calm > 0) begin
                        send_calm--;
                        send_wait = 0;
                    end else begin
                        send_wait = $urandom_range(0, 8);
                        if ($urandom_range(0, 39) == 0) send_calm = $urandom_range(10, 40);
                    end
                end else begin
                    tick_valid <= 1'b0;
                end
            end
        end
    end

    // Result word monitor with random back-pressure.
    int      recv_wait = 0;
    int      recv_calm = 0;
    t_result want;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            result_ready <= 1'b0;
        end else begin
            if (result_ch.valid && result_ready) begin
                if (due_results.size() == 0) begin
                    $display("%0t: unexpected result word: expected none, actual flap %0d phase %0d status %0d reset %0d",
                             $time, result_ch.primary_flap, result_ch.phase_code,
                             result_ch.burn_status, result_ch.regulator_reset);
                    mismatches++;
                end else begin
                    want = due_results.pop_front();
                    flag_field("primary_flap", 16'(want.primary_flap), 16'(result_ch.primary_flap));
                    flag_field("phase_code", 16'(want.phase_code), 16'(result_ch.phase_code));
                    flag_field("burn_status", 16'(want.burn_status), 16'(result_ch.burn_status));
                    flag_field("regulator_reset", 16'(want.regulator_reset),
                               16'(result_ch.regulator_reset));
                    results_checked++;
                end
                if (recv_calm > 0) begin
                    recv_calm--;
                    recv_wait = 0;
                end else begin
                    recv_wait = $urandom_range(0, 8);
                    if ($urandom_range(0, 39) == 0) recv_calm = $urandom_range(10, 40);
                end
            end
            if (recv_wait > 0) begin
                recv_wait--;
                result_ready <= 1'b0;
            end else begin
                result_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    initial begin
        logic [12:0] reg_vals [8];

        cfg_q.start_timeout_min   = 8'd30;
        cfg_q.min_burn_temp       = 13'd900;
        cfg_q.burnout_temp        = 13'd800;
        cfg_q.burnout_timeout_min = 8'd20;
        cfg_q.glow_temp           = 13'd600;
        cfg_q.burnout_flap        = 10'd15;
        cfg_q.glow_timeout        = 8'd10;
        cfg_q.glow_flap           = 10'd10;
        ph_q = PH_STOP; st_q = ST_STOPPED; init_q = 1'b0; started_q = 1'b0;
        restart_q = 1'b0; user_tmr = '0; cold_tmr = '0; flap_q = '0;

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed walk under the reset configuration: field extremes, unused codes,
        // sensor fault at start, regulator saturation, door, restart and stop paths.
        offer(tick_of(0, 0, 0, 3'd0, 0));
        offer(tick_of(8191, 1, 1, 3'd7, 1023));
        offer(tick_of(100, 0, 1, 3'd5, 500));
        offer(tick_of(100, 0, 1, 3'd6, 500));
        offer(tick_of(100, 0, 0, MODE_START, 300));
        offer(tick_of(100, 0, 0, 3'd0, 300));
        offer(tick_of(100, 0, 1, 3'd0, 300));
        offer(tick_of(900, 0, 1, 3'd0, 1023));
        offer(tick_of(1200, 0, 1, 3'd0, 1023));
        offer(tick_of(1200, 0, 1, 3'd0, 1001));
        offer(tick_of(1200, 1, 1, 3'd0, 700));
        offer(tick_of(1200, 0, 1, MODE_RESTART, 700));
        offer(tick_of(1200, 0, 1, MODE_ESTOP, 700));
        offer(tick_of(1200, 0, 1, MODE_ESTOP, 0));
        offer(tick_of(1200, 0, 1, MODE_START, 0));
        offer(tick_of(1200, 0, 1, MODE_RESTART, 0));
        offer(tick_of(1200, 0, 1, MODE_STOP, 0));
        offer(tick_of(0, 1, 1, MODE_STOP, 0));
        offer(tick_of(0, 0, 1, MODE_ESTOP, 0));
        offer(tick_of(0, 0, 1, MODE_RESTART, 0));
        offer(tick_of(8191, 0, 1, 3'd0, 1023));
        offer(tick_of(0, 0, 1, MODE_START, 0));
        offer(tick_of(0, 0, 1, 3'd0, 1000));

        for (int s = 0; s < 6; s++) begin
            settle();
            case (s)
                0: begin
                    reg_vals[CFG_START_TIMEOUT]   = 13'd0;
                    reg_vals[CFG_MIN_BURN_TEMP]   = 13'd900;
                    reg_vals[CFG_BURNOUT_TEMP]    = 13'd800;
                    reg_vals[CFG_BURNOUT_TIMEOUT] = 13'd1;
                    reg_vals[CFG_GLOW_TEMP]       = 13'd600;
                    reg_vals[CFG_BURNOUT_FLAP]    = 13'd1023;
                    reg_vals[CFG_GLOW_TIMEOUT]    = 13'd1;
                    reg_vals[CFG_GLOW_FLAP]       = 13'd1001;
                end
                1: begin
                    for (int r = 0; r < 8; r++) reg_vals[r] = '0;
                end
                2: begin
                    // All ones: narrow registers must drop the upper data bits.
                    for (int r = 0; r < 8; r++) reg_vals[r] = 13'h1FFF;
                end
                3: begin
                    reg_vals[CFG_START_TIMEOUT]   = 13'($urandom_range(0, 2))
                                                  | (13'($urandom_range(0, 31)) << 8);
                    reg_vals[CFG_MIN_BURN_TEMP]   = 13'($urandom_range(0, 2000));
                    reg_vals[CFG_BURNOUT_TEMP]    = 13'($urandom_range(0, 2000));
                    reg_vals[CFG_BURNOUT_TIMEOUT] = 13'($urandom_range(0, 1))
                                                  | (13'($urandom_range(0, 31)) << 8);
                    reg_vals[CFG_GLOW_TEMP]       = 13'($urandom_range(0, 2000));
                    reg_vals[CFG_BURNOUT_FLAP]    = 13'($urandom_range(0, 1023))
                                                  | (13'($urandom_range(0, 7)) << 10);
                    reg_vals[CFG_GLOW_TIMEOUT]    = 13'($urandom_range(0, 1))
                                                  | (13'($urandom_range(0, 31)) << 8);
                    reg_vals[CFG_GLOW_FLAP]       = 13'($urandom_range(0, 1023))
                                                  | (13'($urandom_range(0, 7)) << 10);
                end
                4: begin
                    reg_vals[CFG_START_TIMEOUT]   = 13'd1;
                    reg_vals[CFG_MIN_BURN_TEMP]   = 13'd700;
                    reg_vals[CFG_BURNOUT_TEMP]    = 13'd700;
                    reg_vals[CFG_BURNOUT_TIMEOUT] = 13'd0;
                    reg_vals[CFG_GLOW_TEMP]       = 13'd650;
                    reg_vals[CFG_BURNOUT_FLAP]    = 13'd500;
                    reg_vals[CFG_GLOW_TIMEOUT]    = 13'd0;
                    reg_vals[CFG_GLOW_FLAP]       = 13'd999;
                end
                default: begin
                    for (int r = 0; r < 8; r++) reg_vals[r] = 13'($urandom);
                end
            endcase

            for (int r = 0; r < 8; r++) begin
                @(posedge i_clk);
                cfg_valid <= 1'b1;
                cfg_index <= 3'(r);
                cfg_data  <= reg_vals[r];
                do @(posedge i_clk); while (!cfg_ch.ready);
                case (3'(r))
                    CFG_START_TIMEOUT:   cfg_q.start_timeout_min   = reg_vals[r][7:0];
                    CFG_MIN_BURN_TEMP:   cfg_q.min_burn_temp       = reg_vals[r];
                    CFG_BURNOUT_TEMP:    cfg_q.burnout_temp        = reg_vals[r];
                    CFG_BURNOUT_TIMEOUT: cfg_q.burnout_timeout_min = reg_vals[r][7:0];
                    CFG_GLOW_TEMP:       cfg_q.glow_temp           = reg_vals[r];
                    CFG_BURNOUT_FLAP:    cfg_q.burnout_flap        = reg_vals[r][9:0];
                    CFG_GLOW_TIMEOUT:    cfg_q.glow_timeout        = reg_vals[r][7:0];
                    default:             cfg_q.glow_flap           = reg_vals[r][9:0];
                endcase
                cfg_valid <= 1'b0;
            end

            for (int n = 0; n < ITEMS_PER_SET; n++) offer(draw_tick());
        end

        settle();
        repeat (4) @(posedge i_clk);
        if (mismatches == 0 && due_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

>>> burn_phase_sequencer.f
hw/rtl/bps_pkg.sv
hw/rtl/bps_if.sv
hw/rtl/bps_cfg_regs.sv
hw/rtl/bps_phase_fsm.sv
hw/rtl/burn_phase_sequencer.sv
dv/tb.sv
